>>> sv/m3i_pkg.sv
// ----------------------------------------------------------------------------
// m3i_pkg
// Shared constants for the 3x3 matrix inverse pipeline.
// ----------------------------------------------------------------------------
package m3i_pkg;

    localparam int NUM_ELEM = 9;
    localparam int NUM_COL  = 3;

endpackage

>>> sv/m3i_cofactor.sv
// ----------------------------------------------------------------------------
// m3i_cofactor
// Two-stage cofactor unit: eighteen products, then nine differences.
// ----------------------------------------------------------------------------
module m3i_cofactor #(
    parameter int W = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  v_in,
    input  logic signed [W-1:0]   m [m3i_pkg::NUM_ELEM],
    output logic                  v_out,
    output logic signed [2*W:0]   cof [m3i_pkg::NUM_ELEM],
    output logic signed [W-1:0]   row0 [m3i_pkg::NUM_COL]
);

    localparam int PW = 2 * W;
    localparam int CW = 2 * W + 1;

    logic signed [PW-1:0] pa_reg [m3i_pkg::NUM_ELEM];
    logic signed [PW-1:0] pb_reg [m3i_pkg::NUM_ELEM];
    logic signed [PW-1:0] pa_next [m3i_pkg::NUM_ELEM];
    logic signed [PW-1:0] pb_next [m3i_pkg::NUM_ELEM];
    logic signed [W-1:0]  r0a_reg [m3i_pkg::NUM_COL];
    logic signed [W-1:0]  r0b_reg [m3i_pkg::NUM_COL];
    logic signed [CW-1:0] cof_reg [m3i_pkg::NUM_ELEM];
    logic                 va_reg;
    logic                 vb_reg;

    // negated cofactors swap the operand order
    always_comb
    begin
        pa_next[0] = m[4] * m[8];  pb_next[0] = m[5] * m[7];
        pa_next[1] = m[5] * m[6];  pb_next[1] = m[3] * m[8];
        pa_next[2] = m[3] * m[7];  pb_next[2] = m[4] * m[6];
        pa_next[3] = m[2] * m[7];  pb_next[3] = m[1] * m[8];
        pa_next[4] = m[0] * m[8];  pb_next[4] = m[2] * m[6];
        pa_next[5] = m[1] * m[6];  pb_next[5] = m[0] * m[7];
        pa_next[6] = m[1] * m[5];  pb_next[6] = m[2] * m[4];
        pa_next[7] = m[2] * m[3];  pb_next[7] = m[0] * m[5];
        pa_next[8] = m[0] * m[4];  pb_next[8] = m[3] * m[1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else if (en)
        begin
            va_reg <= v_in;
            vb_reg <= va_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < m3i_pkg::NUM_ELEM; i++)
            begin
                pa_reg[i]  <= pa_next[i];
                pb_reg[i]  <= pb_next[i];
                cof_reg[i] <= CW'(pa_reg[i]) - CW'(pb_reg[i]);
            end
            for (int j = 0; j < m3i_pkg::NUM_COL; j++)
            begin
                r0a_reg[j] <= m[j];
                r0b_reg[j] <= r0a_reg[j];
            end
        end
    end

    assign v_out = vb_reg;
    assign cof   = cof_reg;
    assign row0  = r0b_reg;

endmodule

>>> sv/m3i_det.sv
// ----------------------------------------------------------------------------
// m3i_det
// Two-stage determinant: row-0 expansion with split partial products.
// ----------------------------------------------------------------------------
module m3i_det #(
    parameter int W = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   v_in,
    input  logic signed [2*W:0]    cof_in [m3i_pkg::NUM_ELEM],
    input  logic signed [W-1:0]    row0 [m3i_pkg::NUM_COL],
    output logic                   v_out,
    output logic signed [2*W:0]    cof_out [m3i_pkg::NUM_ELEM],
    output logic signed [3*W+2:0]  det
);

    localparam int CW = 2 * W + 1;
    localparam int DW = 3 * W + 3;
    localparam int HW = CW - W;

    logic signed [W+HW-1:0] hi_reg [m3i_pkg::NUM_COL];
    logic signed [2*W:0]    lo_reg [m3i_pkg::NUM_COL];
    logic signed [CW-1:0]   ca_reg [m3i_pkg::NUM_ELEM];
    logic signed [CW-1:0]   cb_reg [m3i_pkg::NUM_ELEM];
    logic signed [DW-1:0]   det_reg;
    logic signed [DW-1:0]   det_next;
    logic                   va_reg;
    logic                   vb_reg;

    always_comb
    begin
        det_next = '0;
        for (int j = 0; j < m3i_pkg::NUM_COL; j++)
            det_next = det_next + (DW'(hi_reg[j]) <<< W) + DW'(lo_reg[j]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else if (en)
        begin
            va_reg <= v_in;
            vb_reg <= va_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < m3i_pkg::NUM_COL; j++)
            begin
                hi_reg[j] <= row0[j] * $signed(cof_in[j][CW-1:W]);
                lo_reg[j] <= row0[j] * $signed({1'b0, cof_in[j][W-1:0]});
            end
            ca_reg  <= cof_in;
            cb_reg  <= ca_reg;
            det_reg <= det_next;
        end
    end

    assign v_out   = vb_reg;
    assign cof_out = cb_reg;
    assign det     = det_reg;

endmodule

>>> sv/m3i_div_stage.sv
// ----------------------------------------------------------------------------
// m3i_div_stage
// One restoring-division step: quotient bit K for all nine elements.
// ----------------------------------------------------------------------------
module m3i_div_stage #(
    parameter int W  = 32,
    parameter int RW = 100,
    parameter int SW = 52,
    parameter int K  = 0
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           v_in,
    input  logic [RW-1:0]  rem_in [m3i_pkg::NUM_ELEM],
    input  logic [W-1:0]   q_in [m3i_pkg::NUM_ELEM],
    input  logic [RW-1:0]  d2_in,
    input  logic [SW-1:0]  side_in,
    output logic           v_out,
    output logic [RW-1:0]  rem_out [m3i_pkg::NUM_ELEM],
    output logic [W-1:0]   q_out [m3i_pkg::NUM_ELEM],
    output logic [RW-1:0]  d2_out,
    output logic [SW-1:0]  side_out
);

    logic [RW-1:0] dk;
    logic [RW-1:0] rem_next [m3i_pkg::NUM_ELEM];
    logic [W-1:0]  q_next [m3i_pkg::NUM_ELEM];
    logic [RW-1:0] rem_reg [m3i_pkg::NUM_ELEM];
    logic [W-1:0]  q_reg [m3i_pkg::NUM_ELEM];
    logic [RW-1:0] d2_reg;
    logic [SW-1:0] side_reg;
    logic          v_reg;

    assign dk = d2_in << K;

    always_comb
    begin
        for (int i = 0; i < m3i_pkg::NUM_ELEM; i++)
        begin
            rem_next[i] = rem_in[i];
            q_next[i]   = q_in[i];
            if (rem_in[i] >= dk)
            begin
                rem_next[i] = rem_in[i] - dk;
                q_next[i][K] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (en)
            v_reg <= v_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            q_reg    <= q_next;
            d2_reg   <= d2_in;
            side_reg <= side_in;
        end
    end

    assign v_out    = v_reg;
    assign rem_out  = rem_reg;
    assign q_out    = q_reg;
    assign d2_out   = d2_reg;
    assign side_out = side_reg;

endmodule

>>> sv/matrix3x3_inverse.sv
// 3x3 matrix inverse by the adjugate method, fully pipelined: one matrix per
// cycle, through two cofactor stages, two determinant stages, one set-up
// stage, one restoring-division stage per quotient bit and one output
// stage. The division stages set the depth. Results are rounded
// to nearest, ties away from zero, and saturated; a zero determinant gives
// zeros with singular set. A stalled output holds the whole pipeline.
// ----------------------------------------------------------------------------
// matrix3x3_inverse
// Top level: stream ports, set-up stage, divider chain and output register.
// ----------------------------------------------------------------------------
module matrix3x3_inverse #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // m00, m01, m02, m10, m11, m12, m20, m21, m22
    input  logic [((9*WORD_BITS+7)/8)*8-1:0]  s_axis_tdata,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // inv00, inv01, inv02, inv10, inv11, inv12, inv20, inv21, inv22, det_value
    output logic [((10*WORD_BITS+7)/8)*8-1:0] m_axis_tdata,
    // singular, saturated
    output logic [1:0]                        m_axis_tuser
);

    localparam int W   = WORD_BITS;
    localparam int F   = FRAC_BITS;
    localparam int NE  = m3i_pkg::NUM_ELEM;
    localparam int CW  = 2 * W + 1;
    localparam int DW  = 3 * W + 3;
    localparam int RW  = 4 * W + 2 * F + 4;
    localparam int SW  = W + 2 + 2 * NE;
    localparam int OW  = ((10 * W + 7) / 8) * 8;

    logic                en;
    logic signed [W-1:0] m_in [NE];
    logic                v_cof;
    logic signed [CW-1:0] cof_a [NE];
    logic signed [W-1:0] row0 [m3i_pkg::NUM_COL];
    logic                v_det;
    logic signed [CW-1:0] cof_b [NE];
    logic signed [DW-1:0] det;

    logic [DW-1:0]       dmag;
    logic                dneg;
    logic [DW-1:0]       dr;
    logic                det_sat;
    logic [W-1:0]        det_val;
    logic [W-1:0]        det_out;
    logic [RW-1:0]       n_next [NE];
    logic [RW-1:0]       d2_next;
    logic [NE-1:0]       ovf_next;
    logic [NE-1:0]       sgn_next;
    logic [CW-1:0]       cmag;

    logic                v_div [W+1];
    logic [RW-1:0]       rem_div [W+1][NE];
    logic [W-1:0]        q_div [W+1][NE];
    logic [RW-1:0]       d2_div [W+1];
    logic [SW-1:0]       side_div [W+1];

    logic                v_prep_reg;
    logic [RW-1:0]       n_reg [NE];
    logic [RW-1:0]       d2_reg;
    logic [SW-1:0]       side_reg;
    logic [W-1:0]        q_zero [NE];

    logic [W-1:0]        res [NE];
    logic                sat_any;
    logic [SW-1:0]       side_f;
    logic [W-1:0]        qv;
    logic                se;
    logic [W-1:0]        val;

    logic                v_out_reg;
    logic [OW-1:0]       data_reg;
    logic [OW-1:0]       data_next;
    logic [1:0]          user_reg;
    logic [1:0]          user_next;

    assign en            = !v_out_reg || m_axis_tready;
    assign s_axis_tready = en;

    always_comb
    begin
        for (int i = 0; i < NE; i++)
            m_in[i] = $signed(s_axis_tdata[i*W +: W]);
    end

    m3i_cofactor #(.W(W)) u_cof (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .v_in  (s_axis_tvalid),
        .m     (m_in),
        .v_out (v_cof),
        .cof   (cof_a),
        .row0  (row0)
    );

    m3i_det #(.W(W)) u_det (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .v_in    (v_cof),
        .cof_in  (cof_a),
        .row0    (row0),
        .v_out   (v_det),
        .cof_out (cof_b),
        .det     (det)
    );

    // set-up: magnitudes, rounded determinant, scaled numerators
    always_comb
    begin
        dneg    = det[DW-1];
        dmag    = dneg ? DW'(-det) : DW'(det);
        dr      = (dmag + (DW'(1) << (2 * F - 1))) >> (2 * F);
        det_sat = dneg ? (dr > (DW'(1) << (W - 1))) : (dr > ((DW'(1) << (W - 1)) - DW'(1)));
        det_val = det_sat ? (dneg ? (W'(1) << (W - 1)) : ((W'(1) << (W - 1)) - W'(1)))
                          : dr[W-1:0];
        det_out = dneg ? W'(-det_val) : det_val;
        d2_next = RW'(dmag) << 1;
        cmag    = '0;
        for (int i = 0; i < NE; i++)
        begin
            cmag        = cof_b[i][CW-1] ? CW'(-cof_b[i]) : CW'(cof_b[i]);
            n_next[i]   = (RW'(cmag) << (2 * F + 1)) + RW'(dmag);
            ovf_next[i] = n_next[i] >= (d2_next << W);
            sgn_next[i] = cof_b[i][CW-1] ^ dneg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_prep_reg <= 1'b0;
        else if (en)
            v_prep_reg <= v_det;
    end

    // adjugate transpose: output (r,c) divides cofactor (c,r)
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int r = 0; r < m3i_pkg::NUM_COL; r++)
                for (int c = 0; c < m3i_pkg::NUM_COL; c++)
                    n_reg[r*3+c] <= n_next[c*3+r];
            d2_reg   <= d2_next;
            side_reg <= {det == '0, det_sat, det_out,
                         sgn_next[8], sgn_next[5], sgn_next[2],
                         sgn_next[7], sgn_next[4], sgn_next[1],
                         sgn_next[6], sgn_next[3], sgn_next[0],
                         ovf_next[8], ovf_next[5], ovf_next[2],
                         ovf_next[7], ovf_next[4], ovf_next[1],
                         ovf_next[6], ovf_next[3], ovf_next[0]};
        end
    end

    always_comb
    begin
        for (int i = 0; i < NE; i++)
            q_zero[i] = '0;
    end

    assign v_div[0]    = v_prep_reg;
    assign rem_div[0]  = n_reg;
    assign q_div[0]    = q_zero;
    assign d2_div[0]   = d2_reg;
    assign side_div[0] = side_reg;

    for (genvar g = 0; g < W; g++)
    begin : g_div
        m3i_div_stage #(.W(W), .RW(RW), .SW(SW), .K(W - 1 - g)) u_stage (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .v_in     (v_div[g]),
            .rem_in   (rem_div[g]),
            .q_in     (q_div[g]),
            .d2_in    (d2_div[g]),
            .side_in  (side_div[g]),
            .v_out    (v_div[g+1]),
            .rem_out  (rem_div[g+1]),
            .q_out    (q_div[g+1]),
            .d2_out   (d2_div[g+1]),
            .side_out (side_div[g+1])
        );
    end

    // sign, saturation and singular handling
    always_comb
    begin
        side_f  = side_div[W];
        sat_any = side_f[SW-2];
        qv      = '0;
        se      = 1'b0;
        val     = '0;
        for (int i = 0; i < NE; i++)
        begin
            qv  = q_div[W][i];
            se  = side_f[i] || (side_f[NE+i] ? (qv[W-1] && (qv[W-2:0] != '0)) : qv[W-1]);
            val = se ? (side_f[NE+i] ? (W'(1) << (W - 1)) : ((W'(1) << (W - 1)) - W'(1))) : qv;
            res[i]  = side_f[NE+i] ? W'(-val) : val;
            sat_any = sat_any || se;
        end
        data_next = '0;
        user_next = '0;
        if (side_f[SW-1])
            user_next[0] = 1'b1;
        else
        begin
            for (int i = 0; i < NE; i++)
                data_next[i*W +: W] = res[i];
            data_next[NE*W +: W] = side_f[2*NE +: W];
            user_next[1]         = sat_any;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_out_reg <= 1'b0;
        else if (en)
            v_out_reg <= v_div[W];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
            user_reg <= user_next;
        end
    end

    assign m_axis_tvalid = v_out_reg;
    assign m_axis_tdata  = data_reg;
    assign m_axis_tuser  = user_reg;

`ifndef NO_ASSERTIONS
    a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0 && !m_axis_tuser[1])
        else $error("singular transaction carries data");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without a blocked output");
`endif

endmodule

>>> tb/matrix3x3_inverse_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// matrix3x3_inverse_tb
// Streams 3x3 Q16.16 matrices into the inverse pipeline and checks each
// inverse, determinant, singular and saturated flag against an exact
// wide-integer prediction. Both stream sides idle at random and the
// receiver stalls once for a long stretch to fill the pipeline.
// ----------------------------------------------------------------------------
module matrix3x3_inverse_tb;

    localparam int WB      = 32;
    localparam int FB      = 16;
    localparam int IN_W    = ((9 * WB + 7) / 8) * 8;
    localparam int OUT_W   = ((10 * WB + 7) / 8) * 8;
    localparam int LATENCY = WB + 6;
    localparam int LIMIT   = 400000;

    typedef struct packed {
        logic [OUT_W-1:0] data;
        logic [1:0]       flags;
    } inverse_t;

    logic             clk;
    logic             rst_n;
    logic             s_axis_tvalid;
    logic             s_axis_tready;
    logic [IN_W-1:0]  s_axis_tdata;
    logic             m_axis_tvalid;
    logic             m_axis_tready;
    logic [OUT_W-1:0] m_axis_tdata;
    logic [1:0]       m_axis_tuser;

    logic [IN_W-1:0] pending_mats[$];
    inverse_t        expected_invs[$];
    int              errors = 0;
    int              cycle = 0;
    int              hold_left;

    matrix3x3_inverse uut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser)
    );

    function automatic logic [WB-1:0] clip(logic [191:0] mag, logic neg, inout logic sat);
        logic [191:0] lim;
        lim = neg ? (192'd1 << (WB - 1)) : (192'd1 << (WB - 1)) - 1;
        if (mag > lim)
        begin
            mag = lim;
            sat = 1'b1;
        end
        if (neg)
            mag = -mag;
        return mag[WB-1:0];
    endfunction

    function automatic inverse_t invert(logic [IN_W-1:0] d);
        logic signed [191:0] m[3][3];
        logic signed [191:0] cf[3][3];
        logic signed [191:0] det;
        logic [191:0]        dmag, num, q;
        logic                dneg, nneg, sat;
        int                  r1, r2, c1, c2;
        inverse_t            res;
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                m[r][c] = $signed(d[WB*(r*m3i_pkg::NUM_COL+c) +: WB]);
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
            begin
                r1 = (r == 0) ? 1 : 0;
                r2 = (r == 2) ? 1 : 2;
                c1 = (c == 0) ? 1 : 0;
                c2 = (c == 2) ? 1 : 2;
                cf[r][c] = m[r1][c1] * m[r2][c2] - m[r1][c2] * m[r2][c1];
                if ((r + c) % 2 == 1)
                    cf[r][c] = -cf[r][c];
            end
        det = m[0][0] * cf[0][0] + m[0][1] * cf[0][1] + m[0][2] * cf[0][2];
        res = '0;
        if (det == 0)
        begin
            res.flags[0] = 1'b1;
            return res;
        end
        sat  = 1'b0;
        dneg = det < 0;
        dmag = dneg ? -det : det;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
            begin
                nneg = cf[j][i] < 0;
                num  = nneg ? -cf[j][i] : cf[j][i];
                q    = ((num << (2 * FB + 1)) + dmag) / (dmag << 1);
                res.data[WB*(i*m3i_pkg::NUM_COL+j) +: WB] = clip(q, nneg != dneg, sat);
            end
        q = (dmag + (192'd1 << (2 * FB - 1))) >> (2 * FB);
        res.data[WB*m3i_pkg::NUM_ELEM +: WB] = clip(q, dneg, sat);
        res.flags[1] = sat;
        return res;
    endfunction

    function automatic logic [WB-1:0] rand_word(int kind);
        logic [WB-1:0] w;
        case (kind)
            0:       w = $urandom;
            1:       w = WB'($signed(20'($urandom)));
            2:       w = WB'($signed(12'($urandom))) <<< FB;
            default: w = WB'($signed(6'($urandom)));
        endcase
        return w;
    endfunction

    function automatic logic [IN_W-1:0] rand_mat();
        logic [IN_W-1:0] d;
        int              kind;
        d    = '0;
        kind = $urandom_range(0, 3);
        for (int k = 0; k < m3i_pkg::NUM_ELEM; k++)
            d[WB*k +: WB] = rand_word(kind);
        if ($urandom_range(0, 7) == 0)
            for (int c = 0; c < 3; c++)
                d[WB*(6+c) +: WB] = d[WB*c +: WB] + d[WB*(3+c) +: WB];
        return d;
    endfunction

    function automatic logic [IN_W-1:0] diag(logic [WB-1:0] a, logic [WB-1:0] b,
                                            logic [WB-1:0] c);
        logic [IN_W-1:0] d;
        d = '0;
        d[0 +: WB] = a;
        d[WB*4 +: WB] = b;
        d[WB*8 +: WB] = c;
        return d;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                expected_invs.push_back(invert(s_axis_tdata));
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (pending_mats.size() > 0 &&
                    ((cycle > 1200 && cycle < 1700) || $urandom_range(0, 99) >= 23))
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= pending_mats.pop_front();
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // long receiver hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_left <= 0;
        else if (cycle == 400)
            hold_left <= 300;
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    // receiver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (cycle >= 400 && (cycle == 400 || hold_left > 1))
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= (cycle > 1200 && cycle < 1700) || $urandom_range(0, 99) >= 23;
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_invs.size() == 0)
            begin
                $display("%0t: unexpected transaction tdata=%h tuser=%b",
                         $time, m_axis_tdata, m_axis_tuser);
                errors++;
            end
            else
            begin
                inverse_t e;
                e = expected_invs.pop_front();
                for (int k = 0; k < 10; k++)
                    if (m_axis_tdata[WB*k +: WB] !== e.data[WB*k +: WB])
                    begin
                        $display("%0t: word %0d expected %h actual %h", $time, k,
                                 e.data[WB*k +: WB], m_axis_tdata[WB*k +: WB]);
                        errors++;
                    end
                if (m_axis_tuser !== e.flags)
                begin
                    $display("%0t: flags expected %b actual %b", $time, e.flags,
                             m_axis_tuser);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle <= cycle + 1;
        if (cycle > LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        logic [IN_W-1:0] d;
        rst_n  = 1'b0;
        pending_mats.push_back(diag(32'h0001_0000, 32'h0001_0000, 32'h0001_0000));
        pending_mats.push_back('0);
        pending_mats.push_back(diag(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
        pending_mats.push_back(diag(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        pending_mats.push_back(diag(32'h0000_0001, 32'h0000_0001, 32'h0000_0001));
        pending_mats.push_back(diag(32'h0000_0100, 32'h0000_0100, 32'h0000_0100));
        pending_mats.push_back(diag(32'h0003_0000, 32'h0003_0000, 32'h0003_0000));
        pending_mats.push_back(diag(32'hfffe_0000, 32'h0004_0000, 32'h0001_0000));
        pending_mats.push_back(diag(32'h0000_8000, 32'h0002_0000, 32'hffff_0000));
        pending_mats.push_back(diag(32'h0100_0000, 32'h0100_0000, 32'h0100_0000));
        pending_mats.push_back({IN_W{1'b1}});
        pending_mats.push_back({9{32'h7fff_ffff}});
        pending_mats.push_back({9{32'h8000_0000}});
        d = {9{32'h0001_0000}};
        pending_mats.push_back(d);
        d = diag(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
        d[WB*2 +: WB] = 32'h8000_0000;
        d[WB*6 +: WB] = 32'h7fff_ffff;
        pending_mats.push_back(d);
        for (int k = 0; k < 6; k++)
            pending_mats.push_back(rand_mat());
        for (int k = 0; k < 1130; k++)
            pending_mats.push_back(rand_mat());
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        wait (pending_mats.size() == 0);
        @(posedge clk);
        while (s_axis_tvalid || expected_invs.size() > 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        if (errors == 0 && expected_invs.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

>>> matrix3x3_inverse.f
sv/m3i_pkg.sv
sv/m3i_cofactor.sv
sv/m3i_det.sv
sv/m3i_div_stage.sv
sv/matrix3x3_inverse.sv
tb/matrix3x3_inverse_tb.sv
